// ----- hw/rtl/hierarchical_bitmap_id_allocator_assert.svh -----
// Assertion macros for the id allocator.
`ifndef HIERARCHICAL_BITMAP_ID_ALLOCATOR_ASSERT_SVH
`define HIERARCHICAL_BITMAP_ID_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define HBIA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("id allocator: same-cycle check failed");
`define HBIA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("id allocator: next-cycle check failed");
`else
`define HBIA_ASSERT_NOW(label, clk, rst, ante, cons)
`define HBIA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/hbia_pkg.sv -----
package hbia_pkg;

   localparam int WORD_BITS   = 32;
   localparam int LEAF_WORDS  = 32;
   localparam int MAX_REQUEST = 16;

   localparam int WORD_IDX_W  = $clog2(LEAF_WORDS);
   localparam int BIT_IDX_W   = $clog2(WORD_BITS);
   localparam int ID_W        = 10;
   localparam int LIMIT_W     = 11;
   localparam int CNT_W       = 5;
   localparam int STATUS_W    = 2;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 16;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_SET  = 2'd2;

   localparam int PUSH_W = 2;
   localparam logic [PUSH_W-1:0] PUSH_NONE     = 2'd0;
   localparam logic [PUSH_W-1:0] PUSH_PEND     = 2'd1;
   localparam logic [PUSH_W-1:0] PUSH_NO_SPACE = 2'd2;
   localparam logic [PUSH_W-1:0] PUSH_FREE     = 2'd3;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef struct packed {
      logic              load;
      logic              read;
      logic              alloc_commit;
      logic              free_commit;
      logic [PUSH_W-1:0] push;
      logic              push_last;
   } cmd_type;

   typedef struct packed {
      logic req_nonempty;
      logic op_free;
      logic alloc_ok;
      logic pend_valid;
      logic last_id;
      logic out_free;
   } sts_type;

   // {full, index of lowest clear bit}
   function automatic logic [BIT_IDX_W:0] first_zero(word_type w);
      logic [BIT_IDX_W:0] r;
      r = {1'b1, {BIT_IDX_W{1'b0}}};
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (!w[b]) begin
            r = {1'b0, BIT_IDX_W'(b)};
         end
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/hbia_ctrl.sv -----
module hbia_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  hbia_pkg::sts_type sts,
   output hbia_pkg::cmd_type cmd
);
   import hbia_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_EVAL  = 2'd2;
   localparam logic [1:0] S_FLUSH = 2'd3;

   logic [1:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = sts.req_nonempty ? S_READ : S_IDLE;
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (sts.out_free) begin
               if (sts.op_free) begin
                  cmd.free_commit = 1'b1;
                  cmd.push        = PUSH_FREE;
                  cmd.push_last   = 1'b1;
                  state_in        = S_IDLE;
               end else if (sts.alloc_ok) begin
                  cmd.alloc_commit = 1'b1;
                  if (sts.pend_valid) begin
                     cmd.push = PUSH_PEND;
                  end
                  state_in = sts.last_id ? S_FLUSH : S_READ;
               end else if (sts.pend_valid) begin
                  cmd.push      = PUSH_PEND;
                  cmd.push_last = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  cmd.push      = PUSH_NO_SPACE;
                  cmd.push_last = 1'b1;
                  state_in      = S_IDLE;
               end
            end
         end
         S_FLUSH: begin
            if (sts.out_free) begin
               cmd.push      = PUSH_PEND;
               cmd.push_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/hbia_dp.sv -----
module hbia_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [hbia_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                               req_tuser,
   input  logic                               csr_wen,
   input  logic [hbia_pkg::LIMIT_W-1:0]       csr_wdata,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output logic [hbia_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [hbia_pkg::STATUS_W-1:0]      rsp_tuser,
   output logic                               rsp_tlast,
   input  hbia_pkg::cmd_type                  cmd,
   output hbia_pkg::sts_type                  sts
);
   import hbia_pkg::*;

   logic [ID_W-1:0]       req_fid;
   logic [CNT_W-1:0]      req_cnt, req_cnt_sat;

   logic [LIMIT_W-1:0]    limit_ff;
   logic                  op_ff;
   logic [ID_W-1:0]       fid_ff;
   logic [CNT_W-1:0]      cnt_ff, found_ff;
   word_type              root_ff;
   word_type              leaf_mem [LEAF_WORDS];
   logic [LEAF_WORDS-1:0] leaf_vld_ff;

   logic [WORD_IDX_W-1:0] rd_word_ff, rd_addr;
   word_type              rd_data_ff;
   logic                  rd_vld_ff, rd_root_full_ff;

   logic [ID_W-1:0]       pend_id_ff;
   logic                  pend_vld_ff;
   logic                  out_vld_ff, out_last_ff;
   logic [ID_W-1:0]       out_id_ff;
   logic [STATUS_W-1:0]   out_status_ff;

   logic [BIT_IDX_W:0]    root_fz, leaf_fz;
   word_type              leaf_word, alloc_word, free_word, wr_data;
   logic [ID_W-1:0]       new_id;
   logic [BIT_IDX_W-1:0]  fbit;
   logic                  alloc_ok, free_ok, was_full, alloc_full, wr_en, out_free;

   assign req_fid     = req_tdata[ID_W-1:0];
   assign req_cnt     = req_tdata[ID_W +: CNT_W];
   assign req_cnt_sat = (req_cnt > CNT_W'(MAX_REQUEST)) ? CNT_W'(MAX_REQUEST) : req_cnt;

   assign root_fz = first_zero(root_ff);
   assign rd_addr = (op_ff == OP_FREE) ? fid_ff[ID_W-1 -: WORD_IDX_W]
                                       : WORD_IDX_W'(root_fz[BIT_IDX_W-1:0]);

   assign leaf_word  = rd_vld_ff ? rd_data_ff : '0;
   assign leaf_fz    = first_zero(leaf_word);
   assign new_id     = ID_W'({rd_word_ff, leaf_fz[BIT_IDX_W-1:0]});
   assign alloc_ok   = !rd_root_full_ff && !leaf_fz[BIT_IDX_W]
                       && ({1'b0, new_id} < limit_ff);
   assign alloc_word = leaf_word | (word_type'(1) << leaf_fz[BIT_IDX_W-1:0]);
   assign alloc_full = &alloc_word;

   assign fbit      = fid_ff[BIT_IDX_W-1:0];
   assign free_ok   = leaf_word[fbit];
   assign was_full  = &leaf_word;
   assign free_word = leaf_word & ~(word_type'(1) << fbit);

   assign wr_en   = cmd.alloc_commit || (cmd.free_commit && free_ok);
   assign wr_data = cmd.alloc_commit ? alloc_word : free_word;

   assign out_free = !out_vld_ff || rsp_tready;

   assign sts.req_nonempty = (req_tuser == OP_FREE) || (req_cnt != '0);
   assign sts.op_free      = (op_ff == OP_FREE);
   assign sts.alloc_ok     = alloc_ok;
   assign sts.pend_valid   = pend_vld_ff;
   assign sts.last_id      = (CNT_W'(found_ff + 1'b1) == cnt_ff);
   assign sts.out_free     = out_free;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         leaf_mem[rd_word_ff] <= wr_data;
      end
      if (cmd.read) begin
         rd_data_ff <= leaf_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_tuser;
         fid_ff <= req_fid;
         cnt_ff <= req_cnt_sat;
      end
      if (cmd.read) begin
         rd_word_ff      <= rd_addr;
         rd_vld_ff       <= leaf_vld_ff[rd_addr];
         rd_root_full_ff <= root_fz[BIT_IDX_W];
      end
      if (cmd.load) begin
         found_ff <= '0;
      end else if (cmd.alloc_commit) begin
         found_ff <= CNT_W'(found_ff + 1'b1);
      end
      if (cmd.alloc_commit) begin
         pend_id_ff <= new_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= LIMIT_RESET;
         root_ff     <= '0;
         leaf_vld_ff <= '0;
         pend_vld_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            limit_ff <= csr_wdata;
         end
         if (wr_en) begin
            leaf_vld_ff[rd_word_ff] <= 1'b1;
         end
         if (cmd.alloc_commit && alloc_full) begin
            root_ff[rd_word_ff] <= 1'b1;
         end else if (cmd.free_commit && free_ok && was_full) begin
            root_ff[rd_word_ff] <= 1'b0;
         end
         if (cmd.load) begin
            pend_vld_ff <= 1'b0;
         end else if (cmd.alloc_commit) begin
            pend_vld_ff <= 1'b1;
         end else if (cmd.push == PUSH_PEND) begin
            pend_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (cmd.push != PUSH_NONE) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push != PUSH_NONE) begin
         out_last_ff <= cmd.push_last;
      end
      unique case (cmd.push)
         PUSH_PEND: begin
            out_id_ff     <= pend_id_ff;
            out_status_ff <= STATUS_OK;
         end
         PUSH_NO_SPACE: begin
            out_id_ff     <= '0;
            out_status_ff <= STATUS_NO_SPACE;
         end
         PUSH_FREE: begin
            out_id_ff     <= '0;
            out_status_ff <= free_ok ? STATUS_OK : STATUS_NOT_SET;
         end
         default: begin
            out_id_ff     <= out_id_ff;
            out_status_ff <= out_status_ff;
         end
      endcase
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-ID_W){1'b0}}, out_id_ff};
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ----- hw/rtl/hierarchical_bitmap_id_allocator.sv -----
// Channel   Direction  Signals                         Carries
// req       in         req_tvalid/tready/tdata/tuser   one allocate or free request
// rsp       out        rsp_tvalid/tready/tdata/tuser   one id or status per result, tlast ends it
// csr       in         csr_wen/csr_wdata               id limit
//
// A free reads its leaf word, then writes it back and issues its result. An allocate reads
// and updates one leaf word per id handed out, then closes its results with tlast; each id costs one
// read and one write of the single-port leaf word memory.
// Reset clears the id limit to 1024 and marks every id free at once (per-word valid bits).
// A stalled result holds the next one back; requests wait until the previous one is done.
`include "hierarchical_bitmap_id_allocator_assert.svh"

module hierarchical_bitmap_id_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [hbia_pkg::REQ_DATA_W-1:0] req_tdata,  // free_id[9:0], count[14:10], pad
   input  logic                            req_tuser,  // op
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [hbia_pkg::RSP_DATA_W-1:0] rsp_tdata,  // got_id[9:0], pad
   output logic [hbia_pkg::STATUS_W-1:0]   rsp_tuser,  // status[1:0]
   output logic                            rsp_tlast,
   input  logic                            csr_wen,
   input  logic [hbia_pkg::LIMIT_W-1:0]    csr_wdata
);
   import hbia_pkg::*;

   cmd_type cmd;
   sts_type sts;

   hbia_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   hbia_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

   `HBIA_ASSERT_NOW(a_push_room, clock, reset, cmd.push != PUSH_NONE, sts.out_free)
   `HBIA_ASSERT_NOW(a_no_stale_pend, clock, reset, req_tvalid && req_tready, !sts.pend_valid)
   `HBIA_ASSERT_NOW(a_err_result, clock, reset, rsp_tvalid && rsp_tuser != STATUS_OK, rsp_tdata == '0 && rsp_tlast)
   `HBIA_ASSERT_NEXT(a_alloc_advance, clock, reset, cmd.alloc_commit, !req_tready)

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;
   import hbia_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 40;

   typedef struct {
      logic              op;
      logic [ID_W-1:0]   free_id;
      logic [CNT_W-1:0]  count;
      bit                hold;
   } id_request_type;

   typedef struct {
      logic [ID_W-1:0]     got_id;
      logic [STATUS_W-1:0] status;
      logic                last;
   } id_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_wen = 1'b0;
   logic [LIMIT_W-1:0]    csr_wdata = '0;

   id_request_type pending_requests[$];
   id_result_type  expected_results[$];
   id_request_type next_req;
   id_result_type  want;

   logic [WORD_BITS-1:0] tree_words [0:LEAF_WORDS];
   logic [LIMIT_W-1:0]   shadow_limit = LIMIT_RESET;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int mismatches     = 0;
   int idle_cycles    = 0;

   hierarchical_bitmap_id_allocator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      for (int w = 0; w <= LEAF_WORDS; w++) begin
         tree_words[w] = '0;
      end
   end

   function automatic int lowest_clear(logic [WORD_BITS-1:0] word);
      for (int b = 0; b < WORD_BITS; b++) begin
         if (!word[b]) begin
            return b;
         end
      end
      return WORD_BITS;
   endfunction

   // root word 0 marks full leaves; leaf words 1..LEAF_WORDS hold one bit per id
   function automatic bit take_lowest_id(output logic [ID_W-1:0] id);
      int root_bit;
      int leaf;
      int leaf_bit;
      int id_value;
      id = '0;
      root_bit = lowest_clear(tree_words[0]);
      if (root_bit >= LEAF_WORDS) begin
         return 1'b0;
      end
      leaf = 1 + root_bit;
      leaf_bit = lowest_clear(tree_words[leaf]);
      if (leaf_bit >= WORD_BITS) begin
         return 1'b0;
      end
      id_value = root_bit * WORD_BITS + leaf_bit;
      if (id_value >= int'(shadow_limit)) begin
         return 1'b0;
      end
      id = id_value[ID_W-1:0];
      tree_words[leaf][leaf_bit] = 1'b1;
      if (&tree_words[leaf]) begin
         tree_words[0][root_bit] = 1'b1;
      end
      return 1'b1;
   endfunction

   function automatic bit release_id(logic [ID_W-1:0] id);
      int leaf;
      int b;
      bit was_full;
      leaf = 1 + int'(id) / WORD_BITS;
      b = int'(id) % WORD_BITS;
      if (leaf > LEAF_WORDS || !tree_words[leaf][b]) begin
         return 1'b0;
      end
      was_full = &tree_words[leaf];
      tree_words[leaf][b] = 1'b0;
      if (was_full) begin
         tree_words[0][leaf-1] = 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic predict_results(logic op, logic [ID_W-1:0] fid, logic [CNT_W-1:0] cnt);
      id_result_type r;
      logic [ID_W-1:0] id;
      int wanted;
      int found;
      if (op == OP_FREE) begin
         r.got_id = '0;
         r.status = release_id(fid) ? STATUS_OK : STATUS_NOT_SET;
         r.last = 1'b1;
         expected_results.push_back(r);
         return;
      end
      wanted = (int'(cnt) > MAX_REQUEST) ? MAX_REQUEST : int'(cnt);
      found = 0;
      while (found < wanted && take_lowest_id(id)) begin
         r.got_id = id;
         r.status = STATUS_OK;
         r.last = 1'b0;
         expected_results.push_back(r);
         found++;
      end
      if (wanted > 0 && found == 0) begin
         r.got_id = '0;
         r.status = STATUS_NO_SPACE;
         r.last = 1'b1;
         expected_results.push_back(r);
      end else if (found > 0) begin
         expected_results[expected_results.size()-1].last = 1'b1;
      end
   endtask

   task automatic flag_mismatch(string field, int unsigned exp_v, int unsigned act_v);
      $error("%s: expected %0d, got %0d", field, exp_v, act_v);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_results(req_tuser, req_tdata[ID_W-1:0], req_tdata[ID_W +: CNT_W]);
         end
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct &&
                !(pending_requests[0].hold && expected_results.size() != 0)) begin
               next_req = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= REQ_DATA_W'({next_req.count, next_req.free_id});
               req_tuser  <= next_req.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected response: got_id %0d status %0d last %0d",
                   rsp_tdata[ID_W-1:0], rsp_tuser, rsp_tlast);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[ID_W-1:0] !== want.got_id) begin
               flag_mismatch("got_id", want.got_id, rsp_tdata[ID_W-1:0]);
            end
            if (rsp_tuser !== want.status) begin
               flag_mismatch("status", want.status, rsp_tuser);
            end
            if (rsp_tlast !== want.last) begin
               flag_mismatch("last", want.last, rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic add_request(logic op, int fid, int cnt, bit hold = 1'b0);
      id_request_type r;
      r.op = op;
      r.free_id = fid[ID_W-1:0];
      r.count = cnt[CNT_W-1:0];
      r.hold = hold;
      pending_requests.push_back(r);
   endtask

   task automatic add_random_request(int alloc_pct, int free_span);
      int pick;
      pick = $urandom_range(99);
      if ($urandom_range(99) < alloc_pct) begin
         if (pick < 5) begin
            add_request(OP_ALLOC, $urandom, 0, $urandom_range(99) < 3);
         end else if (pick < 15) begin
            add_request(OP_ALLOC, $urandom, $urandom_range(31, 17), $urandom_range(99) < 3);
         end else begin
            add_request(OP_ALLOC, $urandom, $urandom_range(16, 1), $urandom_range(99) < 3);
         end
      end else begin
         add_request(OP_FREE, (pick < 15) ? $urandom_range(1023) : $urandom_range(free_span),
                     $urandom, $urandom_range(99) < 3);
      end
   endtask

   // hold until every request is accepted and answered, let the block settle, then set the limit and stall rates
   task automatic drain_and_configure(logic [LIMIT_W-1:0] limit, int send_pct, int recv_pct);
      @(negedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= limit;
      shadow_limit = limit;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   initial begin
      logic [LIMIT_W-1:0] limit;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      drain_and_configure(LIMIT_RESET, 0, 0);
      add_request(OP_ALLOC, 1023, 1);
      add_request(OP_ALLOC, 0, 16);
      add_request(OP_ALLOC, 0, 31);
      add_request(OP_ALLOC, 0, 0);
      add_request(OP_FREE, 0, 31);
      add_request(OP_FREE, 0, 0);
      add_request(OP_FREE, 1023, 1);
      add_request(OP_ALLOC, 0, 1);
      add_request(OP_FREE, 5, 0);
      add_request(OP_FREE, 17, 0);
      add_request(OP_ALLOC, 0, 2);
      add_request(OP_FREE, 31, 0, 1'b1);
      add_request(OP_ALLOC, 0, 1);

      drain_and_configure(11'd0, 0, 0);
      add_request(OP_ALLOC, 0, 3);
      add_request(OP_FREE, 0, 0);
      add_request(OP_ALLOC, 0, 1);
      add_request(OP_ALLOC, 0, 16);

      drain_and_configure(11'd1, 0, 0);
      add_request(OP_ALLOC, 0, 2);
      add_request(OP_ALLOC, 0, 1);
      add_request(OP_FREE, 1023, 0);

      // fill the whole store, run into no space, then churn
      drain_and_configure(11'h7FF, 0, 69);
      repeat (66) add_request(OP_ALLOC, $urandom, $urandom_range(31, 16));
      repeat (50) add_random_request(50, 1023);

      limit = LIMIT_W'($urandom_range(1024, 1));
      drain_and_configure(limit, 69, 0);
      repeat (50) add_random_request(55, int'(limit) - 1);

      drain_and_configure(LIMIT_RESET, 0, 0);
      repeat (50) add_random_request(60, 1023);

      limit = LIMIT_W'($urandom_range(64, 1));
      drain_and_configure(limit, 36, 36);
      repeat (50) add_random_request(50, 80);

      @(negedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/hbia_pkg.sv
hw/rtl/hbia_ctrl.sv
hw/rtl/hbia_dp.sv
hw/rtl/hierarchical_bitmap_id_allocator.sv
sim/tb.sv
